// ===== sv/assert_macros.svh =====
// assertion macros used by the top rtl file of the noise block
// no dependencies; define ASSERT_OFF to drop every check
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define PN3D_ASSERT_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`define PN3D_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define PN3D_ASSERT_NEVER(lbl, clk, rst, expr, msg)
`define PN3D_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ===== sv/pn3d_pkg.sv =====
// shared constants and types for the 3d gradient noise pipeline
// no dependencies
package pn3d_pkg;
  localparam int TABLE_ENTRIES     = 256;
  localparam int IDX_W             = 8;
  localparam int HASH_W            = 4;
  localparam int COORD_W           = 40;
  localparam int OFFSET_W          = 24;
  localparam int NOISE_W           = 18;
  localparam int FRACTION_BITS_DEF = 16;
  localparam int PIPE_STAGES       = 10;
  localparam int OUT_MAX           = 131071;
  localparam int OUT_MIN           = -131072;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_EVAL = 1'b1
  } cmd_t;

  localparam logic [1:0] REG_OFFSET_X = 2'd0;
  localparam logic [1:0] REG_OFFSET_Y = 2'd1;
  localparam logic [1:0] REG_OFFSET_Z = 2'd2;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic [IDX_W-1:0] data;
  } pn3d_wr_t;
endpackage

// ===== sv/pn3d_if.sv =====
// channel interfaces for sample items, result items and register writes
// depends on pn3d_pkg
interface pn3d_sample_if import pn3d_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      command;
  logic [IDX_W-1:0]          entry_index;
  logic [IDX_W-1:0]          entry_value;
  logic signed [COORD_W-1:0] x_coord;
  logic signed [COORD_W-1:0] y_coord;
  logic signed [COORD_W-1:0] z_coord;
  modport source (output valid, command, entry_index, entry_value, x_coord, y_coord,
                  z_coord, input ready);
  modport sink (input valid, command, entry_index, entry_value, x_coord, y_coord,
                z_coord, output ready);
endinterface

interface pn3d_result_if import pn3d_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [NOISE_W-1:0] noise_value;
  modport source (output valid, noise_value, input ready);
  modport sink (input valid, noise_value, output ready);
endinterface

interface pn3d_cfg_if import pn3d_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [1:0]          index;
  logic [OFFSET_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/pn3d_ram.sv =====
// generic ram, one write port and two registered read ports
// no dependencies
module pn3d_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end
endmodule

// ===== sv/pn3d_hash.sv =====
// corner hashing: three levels of permutation lookups over seven table copies
// depends on pn3d_pkg and pn3d_ram
module pn3d_hash import pn3d_pkg::*; (
  input  logic                         clk,
  input  logic                         adv,
  input  pn3d_wr_t                     wr,
  input  logic [IDX_W-1:0]             cx,
  input  logic [IDX_W-1:0]             cy,
  input  logic [IDX_W-1:0]             cz,
  output logic [7:0][HASH_W-1:0]       hash
);
  localparam int NRAM = 7;

  logic [IDX_W-1:0] cy1, cz1, cz2;
  logic [IDX_W-1:0] ra [NRAM];
  logic [IDX_W-1:0] rb [NRAM];
  logic [IDX_W-1:0] da [NRAM];
  logic [IDX_W-1:0] db [NRAM];
  logic [IDX_W-1:0] a, b, aa, ab, ba, bb;

  always_ff @(posedge clk) begin
    if (adv) begin
      cy1 <= cy;
      cz1 <= cz;
      cz2 <= cz1;
    end
  end

  assign a  = da[0] + cy1;
  assign b  = db[0] + cy1;
  assign aa = da[1] + cz2;
  assign ab = db[1] + cz2;
  assign ba = da[2] + cz2;
  assign bb = db[2] + cz2;

  always_comb begin
    ra[0] = cx;
    rb[0] = cx + IDX_W'(1);
    ra[1] = a;
    rb[1] = a + IDX_W'(1);
    ra[2] = b;
    rb[2] = b + IDX_W'(1);
    ra[3] = aa;
    rb[3] = aa + IDX_W'(1);
    ra[4] = ba;
    rb[4] = ba + IDX_W'(1);
    ra[5] = ab;
    rb[5] = ab + IDX_W'(1);
    ra[6] = bb;
    rb[6] = bb + IDX_W'(1);
  end

  for (genvar g = 0; g < NRAM; g++) begin : g_tab
    pn3d_ram #(.WIDTH(IDX_W), .DEPTH(TABLE_ENTRIES)) u_tab (
      .clk     (clk),
      .we      (wr.en),
      .waddr   (wr.addr),
      .wdata   (wr.data),
      .re      (adv),
      .raddr_a (ra[g]),
      .raddr_b (rb[g]),
      .rdata_a (da[g]),
      .rdata_b (db[g])
    );
  end

  always_comb begin
    hash[0] = da[3][HASH_W-1:0];
    hash[1] = da[4][HASH_W-1:0];
    hash[2] = da[5][HASH_W-1:0];
    hash[3] = da[6][HASH_W-1:0];
    hash[4] = db[3][HASH_W-1:0];
    hash[5] = db[4][HASH_W-1:0];
    hash[6] = db[5][HASH_W-1:0];
    hash[7] = db[6][HASH_W-1:0];
  end
endmodule

// ===== sv/pn3d_fade.sv =====
// three stage fade curve 6t^5-15t^4+10t^3 with rounded products
// depends on pn3d_pkg
module pn3d_fade import pn3d_pkg::*; #(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     adv,
  input  logic [FRACTION_BITS-1:0] t,
  output logic [FRACTION_BITS:0]   fade
);
  localparam int F  = FRACTION_BITS;
  localparam int MW = F + 5;
  localparam int PW = 2 * F + 6;
  localparam logic [2*F:0] HALF_U = {{(F + 1){1'b0}}, 1'b1, {(F - 1){1'b0}}};
  localparam logic signed [PW-1:0] HALF_S = {{(F + 6){1'b0}}, 1'b1, {(F - 1){1'b0}}};
  localparam logic signed [MW-1:0] FIFTEEN = {5'b01111, {F{1'b0}}};
  localparam logic signed [MW-1:0] TEN = {5'b01010, {F{1'b0}}};
  localparam logic signed [F+5:0] ONE_S = {5'b0, 1'b1, {F{1'b0}}};

  logic [F-1:0]          t2, t2d, t3;
  logic signed [MW-1:0]  inner2, inner3;
  logic [2*F-1:0]        tt, tt3;
  logic [2*F:0]          ttr, tt3r;
  logic signed [MW-1:0]  tz, m;
  logic signed [PW-1:0]  p1, p1r, q, qr;
  logic signed [F+5:0]   fq;

  always_comb begin
    tt     = t * t;
    ttr    = {1'b0, tt} + HALF_U;
    tz     = $signed({5'b0, t});
    m      = (tz <<< 2) + (tz <<< 1) - FIFTEEN;
    p1     = $signed({1'b0, t}) * m;
    p1r    = p1 + HALF_S;
    tt3    = t2 * t2d;
    tt3r   = {1'b0, tt3} + HALF_U;
    q      = $signed({1'b0, t3}) * inner3;
    qr     = q + HALF_S;
    fq     = (F + 6)'(qr >>> F);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t2     <= ttr[2*F-1:F];
      t2d    <= t;
      inner2 <= MW'(p1r >>> F) + TEN;
      t3     <= tt3r[2*F-1:F];
      inner3 <= inner2;
      if (fq < 0) begin
        fade <= '0;
      end else if (fq > ONE_S) begin
        fade <= ONE_S[F:0];
      end else begin
        fade <= fq[F:0];
      end
    end
  end
endmodule

// ===== sv/pn3d_blend.sv =====
// corner gradients and the three levels of trilinear blending
// depends on pn3d_pkg
module pn3d_blend import pn3d_pkg::*; #(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            adv,
  input  logic [FRACTION_BITS-1:0]        fx,
  input  logic [FRACTION_BITS-1:0]        fy,
  input  logic [FRACTION_BITS-1:0]        fz,
  input  logic [7:0][HASH_W-1:0]          hash,
  input  logic [FRACTION_BITS:0]          u,
  input  logic [FRACTION_BITS:0]          v,
  input  logic [FRACTION_BITS:0]          w,
  output logic signed [FRACTION_BITS+3:0] lerp_out
);
  localparam int F  = FRACTION_BITS;
  localparam int LW = F + 4;
  localparam int PW = 2 * F + 6;
  localparam logic signed [LW-1:0] ONE_L = {3'b0, 1'b1, {F{1'b0}}};
  localparam logic signed [PW-1:0] HALF_S = {{(F + 6){1'b0}}, 1'b1, {(F - 1){1'b0}}};

  function automatic logic signed [LW-1:0] grad(input logic [HASH_W-1:0] h,
      input logic signed [LW-1:0] x, input logic signed [LW-1:0] y,
      input logic signed [LW-1:0] z);
    logic signed [LW-1:0] gu, gv;
    gu = (h < HASH_W'(8)) ? x : y;
    if (h < HASH_W'(4)) begin
      gv = y;
    end else begin
      gv = (h == HASH_W'(12) || h == HASH_W'(14)) ? x : z;
    end
    return (h[0] ? -gu : gu) + (h[1] ? -gv : gv);
  endfunction

  function automatic logic signed [LW-1:0] lerp_fin(input logic signed [LW-1:0] a,
      input logic signed [LW-1:0] d, input logic [F:0] wt);
    logic signed [PW-1:0] p;
    p = $signed({1'b0, wt}) * d;
    p = p + HALF_S;
    return a + LW'(p >>> F);
  endfunction

  logic signed [LW-1:0] x0, y0, z0, x1, y1, z1;
  logic signed [LW-1:0] g4 [8];
  logic signed [LW-1:0] a5 [4];
  logic signed [LW-1:0] d5 [4];
  logic signed [LW-1:0] l6 [4];
  logic signed [LW-1:0] a7 [2];
  logic signed [LW-1:0] d7 [2];
  logic signed [LW-1:0] l8 [2];
  logic signed [LW-1:0] a9, d9;
  logic [F:0] u5, v5, v6, v7, w5, w6, w7, w8, w9;

  always_comb begin
    x0 = $signed({4'b0, fx});
    y0 = $signed({4'b0, fy});
    z0 = $signed({4'b0, fz});
    x1 = x0 - ONE_L;
    y1 = y0 - ONE_L;
    z1 = z0 - ONE_L;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      g4[0] <= grad(hash[0], x0, y0, z0);
      g4[1] <= grad(hash[1], x1, y0, z0);
      g4[2] <= grad(hash[2], x0, y1, z0);
      g4[3] <= grad(hash[3], x1, y1, z0);
      g4[4] <= grad(hash[4], x0, y0, z1);
      g4[5] <= grad(hash[5], x1, y0, z1);
      g4[6] <= grad(hash[6], x0, y1, z1);
      g4[7] <= grad(hash[7], x1, y1, z1);
      for (int i = 0; i < 4; i++) begin
        a5[i] <= g4[2*i];
        d5[i] <= g4[2*i+1] - g4[2*i];
        l6[i] <= lerp_fin(a5[i], d5[i], u5);
      end
      for (int i = 0; i < 2; i++) begin
        a7[i] <= l6[2*i];
        d7[i] <= l6[2*i+1] - l6[2*i];
        l8[i] <= lerp_fin(a7[i], d7[i], v7);
      end
      a9       <= l8[0];
      d9       <= l8[1] - l8[0];
      lerp_out <= lerp_fin(a9, d9, w9);
      u5 <= u;
      v5 <= v;
      v6 <= v5;
      v7 <= v6;
      w5 <= w;
      w6 <= w5;
      w7 <= w6;
      w8 <= w7;
      w9 <= w8;
    end
  end
endmodule

// ===== sv/perlin_noise_3d_point_top.sv =====
// 3d gradient noise, one point per item
// throughput one item per cycle unless stalled; ten stage pipeline, seven table copies
// a load waits while an evaluate is still in its first two table lookup stages
// output skid pair lets the pipeline take items while a result waits
// synchronous reset clears valids and offsets; the table is undefined until loaded
`include "assert_macros.svh"
module perlin_noise_3d_point_top import pn3d_pkg::*; #(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input logic           clk,
  input logic           rst,
  pn3d_sample_if.sink   sample,
  pn3d_result_if.source result,
  pn3d_cfg_if.sink      cfg
);
  localparam int F  = FRACTION_BITS;
  localparam int LW = F + 4;
  localparam int EW = ((LW > NOISE_W) ? LW : NOISE_W) + 1;
  localparam logic signed [EW-1:0] SAT_HI = EW'(OUT_MAX);
  localparam logic signed [EW-1:0] SAT_LO = EW'(OUT_MIN);

  logic [OFFSET_W-1:0]        off_x, off_y, off_z;
  logic [COORD_W:0]           sx, sy, sz;
  logic                       adv, pend, acc, is_load, acc_eval;
  pn3d_wr_t                   wr;
  logic [PIPE_STAGES-1:0]     vld;
  logic [F-1:0]               fr1 [3];
  logic [F-1:0]               fr2 [3];
  logic [F-1:0]               fr3 [3];
  logic [F:0]                 fd [3];
  logic [7:0][HASH_W-1:0]     hash;
  logic signed [LW-1:0]       r10;
  logic signed [EW-1:0]       rx;
  logic signed [NOISE_W-1:0]  sat, o_d, s_d;
  logic                       o_v, s_v, push, pop;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      off_x <= '0;
      off_y <= '0;
      off_z <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_OFFSET_X: off_x <= cfg.data;
        REG_OFFSET_Y: off_y <= cfg.data;
        REG_OFFSET_Z: off_z <= cfg.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    sx = {sample.x_coord[COORD_W-1], sample.x_coord}
         + {{(COORD_W + 1 - OFFSET_W){1'b0}}, off_x};
    sy = {sample.y_coord[COORD_W-1], sample.y_coord}
         + {{(COORD_W + 1 - OFFSET_W){1'b0}}, off_y};
    sz = {sample.z_coord[COORD_W-1], sample.z_coord}
         + {{(COORD_W + 1 - OFFSET_W){1'b0}}, off_z};
  end

  assign adv          = !s_v;
  assign pend         = vld[0] || vld[1];
  assign is_load      = cmd_t'(sample.command) == CMD_LOAD;
  assign sample.ready = adv && !(is_load && pend);
  assign acc          = sample.valid && sample.ready;
  assign acc_eval     = acc && !is_load;
  assign wr           = '{en: acc && is_load, addr: sample.entry_index,
                          data: sample.entry_value};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[PIPE_STAGES-2:0], acc_eval};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fr1[0] <= sx[F-1:0];
      fr1[1] <= sy[F-1:0];
      fr1[2] <= sz[F-1:0];
      fr2    <= fr1;
      fr3    <= fr2;
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_fade
    pn3d_fade #(.FRACTION_BITS(F)) u_fade (
      .clk  (clk),
      .adv  (adv),
      .t    (fr1[g]),
      .fade (fd[g])
    );
  end

  pn3d_hash u_hash (
    .clk  (clk),
    .adv  (adv),
    .wr   (wr),
    .cx   (sx[F+IDX_W-1:F]),
    .cy   (sy[F+IDX_W-1:F]),
    .cz   (sz[F+IDX_W-1:F]),
    .hash (hash)
  );

  pn3d_blend #(.FRACTION_BITS(F)) u_blend (
    .clk      (clk),
    .adv      (adv),
    .fx       (fr3[0]),
    .fy       (fr3[1]),
    .fz       (fr3[2]),
    .hash     (hash),
    .u        (fd[0]),
    .v        (fd[1]),
    .w        (fd[2]),
    .lerp_out (r10)
  );

  always_comb begin
    rx = {{(EW - LW){r10[LW-1]}}, r10};
    if (rx > SAT_HI) begin
      sat = NOISE_W'(OUT_MAX);
    end else if (rx < SAT_LO) begin
      sat = NOISE_W'(OUT_MIN);
    end else begin
      sat = rx[NOISE_W-1:0];
    end
  end

  assign push = adv && vld[PIPE_STAGES-1];
  assign pop  = o_v && result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_v <= 1'b0;
      s_v <= 1'b0;
    end else if (!o_v || pop) begin
      if (s_v) begin
        o_v <= 1'b1;
        s_v <= 1'b0;
      end else begin
        o_v <= push;
      end
    end else if (push) begin
      s_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!o_v || pop) begin
      o_d <= s_v ? s_d : sat;
    end else if (push) begin
      s_d <= sat;
    end
  end

  assign result.valid       = o_v;
  assign result.noise_value = o_d;

  `PN3D_ASSERT_NEVER(a_load_order, clk, rst, acc && is_load && pend, "load taken during lookup")
  `PN3D_ASSERT_NEVER(a_spare_alone, clk, rst, s_v && !o_v, "spare item without output item")
  `PN3D_ASSERT_NEXT(a_stall_hold, clk, rst, !adv, $stable(vld), "pipeline moved while stalled")
endmodule
